// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the escape-time block.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/mbe_pkg.sv =====
// Package of the Mandelbrot escape-time block: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 32;
    // cycle-detection span counts up to 2^32, so one bit more than the count
    localparam int SPAN_W = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 32'd1024;

    // product that the shared multiplier works on
    typedef enum logic [2:0] {
        OP_YY  = 3'd0,  // c_imag squared
        OP_XX  = 3'd1,  // (c_real - 1/4) squared
        OP_T   = 3'd2,  // q * (q + x), cardioid test
        OP_UU  = 3'd3,  // (c_real + 1) squared, bulb test
        OP_ZRI = 3'd4,  // 2 * zr * zi
        OP_SR  = 3'd5,  // zr squared
        OP_SI  = 3'd6   // zi squared
    } op_t;

    typedef struct packed {
        logic load;      // take a new point, clear z and counters
        logic mul_lo;    // multiplier: low half of operand b
        logic mul_hi;    // multiplier: high half of operand b
        logic cap;       // capture the finished product for op
        logic out_load;  // move the result into the output register
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic known;     // point lies in cardioid or bulb (valid on OP_UU capture)
        logic escape;    // |z|^2 > 4 (valid on OP_SI capture)
        logic loop_hit;  // z repeats the marked value
        logic at_limit;  // iteration count reached the iteration limit
    } status_t;

endpackage

// ===== sv/mbe_stream_if.sv =====
// Valid/ready channel interfaces for points and results.
// Depends on mbe_pkg for the payload widths.
`timescale 1ns / 1ps

interface mbe_point_if;
    import mbe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_result_if;
    import mbe_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] iteration_count;
    logic               in_set;

    modport source (output valid, output iteration_count, output in_set, input ready);
    modport sink   (input valid, input iteration_count, input in_set, output ready);
endinterface

// ===== sv/mbe_mul.sv =====
// Shared signed multiplier, each product in steps: low half of b, then high half.
// Standalone; used by mbe_datapath.
`timescale 1ns / 1ps

module mbe_mul #(
    parameter int Z_W = 36
) (
    input  logic                    clk,
    input  logic                    lo_step,
    input  logic                    hi_step,
    input  logic signed [Z_W-1:0]   a,
    input  logic signed [Z_W-1:0]   b,
    output logic signed [2*Z_W-1:0] prod
);

    localparam int HB    = Z_W / 2;
    localparam int P_W   = Z_W + HB + 1;
    localparam int ACC_W = 2 * Z_W;

    logic signed [HB:0]      b_part;
    logic signed [P_W-1:0]   part_prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // select the half of b for this step; the low half is unsigned
    always_comb
    begin
        if (lo_step)
        begin
            b_part = $signed({1'b0, b[HB-1:0]});
        end
        else
        begin
            b_part = (HB+1)'($signed(b[Z_W-1:HB]));
        end
    end

    assign part_prod = P_W'(a) * P_W'(b_part);

    // start with the low partial product, add the high one shifted
    always_comb
    begin
        if (lo_step)
        begin
            acc_next = ACC_W'(part_prod);
        end
        else
        begin
            acc_next = acc_reg + (ACC_W'(part_prod) <<< HB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lo_step || hi_step)
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;

endmodule

// ===== sv/mbe_ctrl.sv =====
// Controller of the escape-time block: sequences multiplier steps and captures,
// owns the request handshakes. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mbe_pkg::status_t status,
    output mbe_pkg::cmd_t    cmd
);
    import mbe_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MLO  = 5'b00010,
        ST_MHI  = 5'b00100,
        ST_CAP  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    op_t    op_reg;
    op_t    op_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state, next op and commands
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op_reg;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_YY;
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = ST_MLO;
                unique case (op_reg)
                    OP_YY: op_next = OP_XX;
                    OP_XX: op_next = OP_T;
                    OP_T:  op_next = OP_UU;
                    OP_UU:
                    begin
                        if (status.known || status.at_limit)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            op_next = OP_ZRI;
                        end
                    end
                    OP_ZRI: op_next = OP_SR;
                    OP_SR:  op_next = OP_SI;
                    OP_SI:
                    begin
                        if (status.escape || status.loop_hit || status.at_limit)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            op_next = OP_ZRI;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_YY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/mbe_datapath.sv =====
// Datapath of the escape-time block: point and z registers, region tests,
// escape and cycle detection, limit register, result register.
// Depends on mbe_pkg and mbe_mul.
`timescale 1ns / 1ps

module mbe_datapath #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mbe_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  mbe_pkg::cmd_t                      cmd,
    output mbe_pkg::status_t                   status,
    input  logic signed [mbe_pkg::COORD_W-1:0] c_real,
    input  logic signed [mbe_pkg::COORD_W-1:0] c_imag,
    output logic [mbe_pkg::COUNT_W-1:0]        iteration_count,
    output logic                               in_set
);
    import mbe_pkg::*;

    localparam int FRAC  = COORD_FRAC_BITS;
    localparam int C_INT = COORD_W - FRAC;
    // integer bits of z: enough for |z| <= 5 + |c|
    localparam int ZI    = (C_INT > 6) ? C_INT + 2 : 8;
    localparam int Z_W   = FRAC + ZI;
    localparam int ACC_W = 2 * Z_W;
    // squares kept after a non-escaping step are at most 4.0
    localparam int S_W   = FRAC + 3;
    localparam int SUM_W = S_W + 1;

    localparam logic signed [Z_W-1:0]   FX_ONE       = Z_W'(1) << FRAC;
    localparam logic signed [Z_W-1:0]   FX_QUARTER   = Z_W'(1) << (FRAC - 2);
    localparam logic signed [Z_W-1:0]   FX_SIXTEENTH = Z_W'(1) << (FRAC - 4);
    localparam logic signed [ACC_W-1:0] FX_FOUR_ACC  = ACC_W'(4) << FRAC;
    localparam logic [SUM_W-1:0]        FX_FOUR_SUM  = SUM_W'(4) << FRAC;

    logic signed [Z_W-1:0]   cr_reg, ci_reg;
    logic signed [Z_W-1:0]   zr_reg, zi_reg;
    logic signed [Z_W-1:0]   yy_reg, q_reg;
    logic signed [Z_W-1:0]   mark_r_reg, mark_i_reg;
    logic                    card_reg;
    logic [S_W-1:0]          sr_reg, si_reg;
    logic                    sr_big_reg;
    logic                    esc_reg;
    logic [COUNT_W-1:0]      n_reg;
    logic [COUNT_W-1:0]      limit_reg;
    logic [SPAN_W-1:0]       span_reg, run_reg;
    logic [COUNT_W-1:0]      count_out_reg;
    logic                    in_set_out_reg;

    logic signed [Z_W-1:0]   x, u;
    logic                    x_ok, u_ok, ci_ok;
    logic signed [Z_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W-1:0] prod, prod_f, prod_h;
    logic signed [Z_W-1:0]   prod_lo;
    logic [S_W-1:0]          sq_new;
    logic                    si_big;
    logic [SUM_W-1:0]        sq_sum;
    logic                    bulb_in;
    logic [SPAN_W-1:0]       run_inc;

    // shifted point for the cardioid and bulb tests
    assign x     = cr_reg - FX_QUARTER;
    assign u     = cr_reg + FX_ONE;
    assign x_ok  = (x <= FX_ONE) && (x >= -FX_ONE);
    assign u_ok  = (u <= FX_ONE) && (u >= -FX_ONE);
    assign ci_ok = (ci_reg <= FX_ONE) && (ci_reg >= -FX_ONE);

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.op)
            OP_YY:
            begin
                mul_a = ci_reg;
                mul_b = ci_reg;
            end
            OP_XX:
            begin
                mul_a = x;
                mul_b = x;
            end
            OP_T:
            begin
                mul_a = q_reg;
                mul_b = q_reg + x;
            end
            OP_UU:
            begin
                mul_a = u;
                mul_b = u;
            end
            OP_SR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            OP_SI:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    mbe_mul #(
        .Z_W(Z_W)
    ) u_mul (
        .clk     (clk),
        .lo_step (cmd.mul_lo),
        .hi_step (cmd.mul_hi),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (prod)
    );

    // floor of the product: arithmetic shift right
    assign prod_f  = prod >>> FRAC;
    assign prod_h  = prod >>> (FRAC - 1);
    assign prod_lo = $signed(prod_f[Z_W-1:0]);
    assign sq_new  = prod_f[S_W-1:0];

    // escape test on the fresh squares
    assign si_big  = prod_f > FX_FOUR_ACC;
    assign sq_sum  = {1'b0, sr_reg} + {1'b0, sq_new};
    assign bulb_in = (prod_lo + yy_reg) <= FX_SIXTEENTH;
    assign run_inc = run_reg + SPAN_W'(1);

    assign status.known    = ci_ok && ((x_ok && card_reg) || (u_ok && bulb_in));
    assign status.escape   = sr_big_reg || si_big || (sq_sum > FX_FOUR_SUM);
    assign status.loop_hit = (zr_reg == mark_r_reg) && (zi_reg == mark_i_reg);
    assign status.at_limit = (n_reg == limit_reg);

    // iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // point, z, squares and cycle-detection registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg     <= Z_W'(c_real);
            ci_reg     <= Z_W'(c_imag);
            zr_reg     <= '0;
            zi_reg     <= '0;
            sr_reg     <= '0;
            si_reg     <= '0;
            sr_big_reg <= 1'b0;
            esc_reg    <= 1'b0;
            n_reg      <= '0;
            mark_r_reg <= '0;
            mark_i_reg <= '0;
            span_reg   <= SPAN_W'(1);
            run_reg    <= '0;
        end
        else if (cmd.cap)
        begin
            unique case (cmd.op)
                OP_YY: yy_reg <= prod_lo;
                OP_XX: q_reg <= prod_lo + yy_reg;
                OP_T:  card_reg <= (prod_lo <= (yy_reg >>> 2));
                OP_UU: ;
                OP_ZRI:
                begin
                    zr_reg <= $signed({{(Z_W-S_W){1'b0}}, sr_reg})
                            - $signed({{(Z_W-S_W){1'b0}}, si_reg}) + cr_reg;
                    zi_reg <= $signed(prod_h[Z_W-1:0]) + ci_reg;
                    n_reg  <= n_reg + COUNT_W'(1);
                end
                OP_SR:
                begin
                    sr_reg     <= sq_new;
                    sr_big_reg <= prod_f > FX_FOUR_ACC;
                end
                OP_SI:
                begin
                    si_reg <= sq_new;
                    if (status.escape)
                    begin
                        esc_reg <= 1'b1;
                    end
                    else if (!status.loop_hit)
                    begin
                        // advance the cycle detector, move the mark at span end
                        if (run_inc == span_reg)
                        begin
                            mark_r_reg <= zr_reg;
                            mark_i_reg <= zi_reg;
                            span_reg   <= span_reg << 1;
                            run_reg    <= '0;
                        end
                        else
                        begin
                            run_reg <= run_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            count_out_reg  <= esc_reg ? n_reg : limit_reg;
            in_set_out_reg <= !esc_reg;
        end
    end

    assign iteration_count = count_out_reg;
    assign in_set          = in_set_out_reg;

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: controller, datapath, assertions.
// Depends on mbe_pkg, mbe_stream_if, mbe_ctrl, mbe_datapath, assert_macros.svh.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------
//   point    | in  | c_real, c_imag (signed Q4.28)   | valid/ready
//   result   | out | iteration_count, in_set         | valid/ready
//   cfg      | in  | cfg_wr_data (iteration limit)   | cfg_wr_en
//
// One shared multiplier serves all products, each in steps: low half, high half,
// capture. A point in the cardioid or bulb needs the four region-test products;
// a point that runs n iterations needs three more products per iteration.
// Reset clears the controller and sets the iteration limit to 1024.
// A new point is taken while a finished result waits; a stalled result holds
// the block in its done state until the output register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mandelbrot_escape_time #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mbe_pkg::COUNT_W-1:0] cfg_wr_data,
    mbe_point_if.sink                   point,
    mbe_result_if.source                result
);
    import mbe_pkg::*;

    cmd_t    cmd;
    status_t status;

    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mbe_datapath #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .c_real          (point.c_real),
        .c_imag          (point.c_imag),
        .iteration_count (result.iteration_count),
        .in_set          (result.in_set)
    );

    // multiplier steps run low, high, capture
    `ASSERT_NEXT(a_mul_lo_hi, cmd.mul_lo, cmd.mul_hi, "low multiplier step without high step")
    `ASSERT_NEXT(a_mul_hi_cap, cmd.mul_hi, cmd.cap, "high multiplier step without capture")
    // never overwrite a result that waits
    `ASSERT_CLK(a_out_free, cmd.out_load |-> (!result.valid || result.ready), "result overwritten")
    // no multiplier step, capture or output load while a request can be taken
    `ASSERT_CLK(a_idle_quiet, point.ready |-> !(cmd.mul_lo || cmd.mul_hi || cmd.cap || cmd.out_load), "datapath busy while ready")

endmodule
